// ===== src/kmpsm_pkg.sv =====
// Shared types, constants and helpers of the streaming KMP matcher.
package kmpsm_pkg;

	// Default sizes, handed down from the top level.
	localparam int MAX_PATTERN_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;

	// Fixed field widths.
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 5;
	localparam int START_W   = 32;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	// Depth of the queues on the input and the result side.
	localparam int QUEUE_DEPTH = 2;

	// Skip table code for an empty chain.
	localparam logic [LEN_W-1:0] SKIP_NONE = 5'h1F;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} in_item_t;

	typedef struct packed {
		logic               match_found;
		logic [START_W-1:0] match_start;
	} out_item_t;

	// Status of the table unit as seen by the front and the back.
	typedef struct packed {
		logic             ready;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] border_full;
	} tbl_t;

	// Pattern byte idx, bytes 0 to 7 in the low word, 8 to 15 in the high word.
	function automatic logic [BYTE_W-1:0] pat_byte(
		input logic [CFG_W-1:0] lo,
		input logic [CFG_W-1:0] hi,
		input logic [3:0]       idx
	);
		logic [CFG_W-1:0] word;
		word = idx[3] ? hi : lo;
		return word[idx[2:0]*BYTE_W +: BYTE_W];
	endfunction

endpackage

// ===== src/kmpsm_fifo.sv =====
// Small register queue used between the front, the back and the result port.
module kmpsm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");

endmodule

// ===== src/kmpsm_tables.sv =====
// Configuration registers and the sequencer that derives the border and skip tables.
module kmpsm_tables #(
	parameter int MAX_PATTERN = kmpsm_pkg::MAX_PATTERN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kmpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kmpsm_pkg::CFG_W-1:0]      cfg_data,
	input  logic [kmpsm_pkg::LEN_W-1:0]      skip_addr,
	output logic [kmpsm_pkg::LEN_W-1:0]      skip_data,
	output logic [kmpsm_pkg::CFG_W-1:0]      pattern_low,
	output logic [kmpsm_pkg::CFG_W-1:0]      pattern_high,
	output logic                             restart,
	output kmpsm_pkg::tbl_t                  tbl
);
	import kmpsm_pkg::*;

	localparam int BIW = $clog2(MAX_PATTERN + 1);
	localparam int SIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	typedef enum logic [1:0] {ST_INIT, ST_BORDER, ST_SKIP, ST_READY} state_t;

	state_t           state_q, state_d;
	logic [LEN_W-1:0] i_q, i_d;
	logic [LEN_W-1:0] k_q, k_d;
	logic [LEN_W-1:0] bfull_q, bfull_d;

	logic [CFG_W-1:0] pattern_low_q;
	logic [CFG_W-1:0] pattern_high_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic [LEN_W-1:0] len;

	logic [LEN_W-1:0] border_q [0:MAX_PATTERN];
	logic [LEN_W-1:0] skip_q   [0:MAX_PATTERN-1];

	logic [LEN_W-1:0]  border_addr, border_rd;
	logic [LEN_W-1:0]  skip_sel, skip_rd;
	logic [BYTE_W-1:0] pi, pk, pb;
	logic [LEN_W-1:0]  k_inc, i_inc;
	logic              last_i;

	logic              bt_we, st_we;
	logic [LEN_W-1:0]  bt_waddr, bt_wdata, st_waddr, st_wdata;

	assign restart = cfg_we && (cfg_index == REG_PATTERN_LOW ||
		cfg_index == REG_PATTERN_HIGH || cfg_index == REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Lengths out of range are clamped to the usable range.
	always_comb begin
		if (pattern_length_q == '0) begin
			len = LEN_W'(1);
		end else if (pattern_length_q > LEN_W'(MAX_PATTERN)) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = pattern_length_q;
		end
	end

	assign pattern_low  = pattern_low_q;
	assign pattern_high = pattern_high_q;

	// One read port per table; the matcher owns the skip port once the tables are ready.
	assign border_addr = (state_q == ST_BORDER) ? k_q : i_q;
	assign border_rd   = border_q[border_addr[BIW-1:0]];
	assign skip_sel    = (state_q == ST_READY) ? skip_addr : border_rd;
	assign skip_rd     = skip_q[skip_sel[SIW-1:0]];
	assign skip_data   = skip_rd;

	assign pi     = pat_byte(pattern_low_q, pattern_high_q, i_q[3:0]);
	assign pk     = pat_byte(pattern_low_q, pattern_high_q, k_q[3:0]);
	assign pb     = pat_byte(pattern_low_q, pattern_high_q, border_rd[3:0]);
	assign k_inc  = k_q + LEN_W'(pi == pk);
	assign i_inc  = i_q + LEN_W'(1);
	assign last_i = (i_inc == len);

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		k_d      = k_q;
		bfull_d  = bfull_q;
		bt_we    = 1'b0;
		bt_waddr = i_inc;
		bt_wdata = k_inc;
		st_we    = 1'b0;
		st_waddr = i_q;
		st_wdata = border_rd;
		case (state_q)
			ST_INIT: begin
				bt_we    = 1'b1;
				bt_waddr = LEN_W'(1);
				bt_wdata = '0;
				st_we    = 1'b1;
				st_waddr = '0;
				st_wdata = SKIP_NONE;
				i_d      = LEN_W'(1);
				k_d      = '0;
				if (len == LEN_W'(1)) begin
					bfull_d = '0;
					state_d = ST_READY;
				end else begin
					state_d = ST_BORDER;
				end
			end
			ST_BORDER: begin
				// Either fall back one link of the border chain or settle border[i+1].
				if (k_q != '0 && pi != pk) begin
					k_d = border_rd;
				end else begin
					bt_we = 1'b1;
					k_d   = k_inc;
					if (last_i) begin
						bfull_d = k_inc;
						i_d     = LEN_W'(1);
						state_d = ST_SKIP;
					end else begin
						i_d = i_inc;
					end
				end
			end
			ST_SKIP: begin
				st_we    = 1'b1;
				st_wdata = (pi == pb) ? skip_rd : border_rd;
				if (last_i) begin
					state_d = ST_READY;
				end else begin
					i_d = i_inc;
				end
			end
			ST_READY: begin
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			i_q     <= '0;
			k_q     <= '0;
			bfull_q <= '0;
		end else if (restart) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			k_q     <= k_d;
			bfull_q <= bfull_d;
		end
	end

	always_ff @(posedge clk) begin
		if (bt_we) begin
			border_q[bt_waddr[BIW-1:0]] <= bt_wdata;
		end
		if (st_we) begin
			skip_q[st_waddr[SIW-1:0]] <= st_wdata;
		end
	end

	assign tbl = '{ready: (state_q == ST_READY), len: len, border_full: bfull_q};

	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> !tbl.ready)
		else $error("tables reported ready right after a register write");
	a_border_short: assert property (@(posedge clk) disable iff (!arst_n)
		tbl.ready |-> (bfull_q < len))
		else $error("border of the full pattern is not a proper border");

endmodule

// ===== src/kmpsm_front.sv =====
// Input side: takes items, numbers the text bytes and queues them for the matcher.
module kmpsm_front #(
	parameter int POSITION_BITS = kmpsm_pkg::POSITION_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         restart,
	input  logic                                         tbl_ready,
	input  logic                                         push,
	input  kmpsm_pkg::in_item_t                          item,
	output logic                                         full,
	input  logic                                         q_full,
	output logic                                         q_push,
	output logic [POSITION_BITS+kmpsm_pkg::BYTE_W:0]     q_data
);
	import kmpsm_pkg::*;

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_n;

	assign full   = q_full || !tbl_ready;
	assign q_push = push && !full;

	// The position saturates at its all-ones value.
	assign pos_n  = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
	assign q_data = {pos_n, item.text_byte, item.end_of_text};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (restart) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= item.end_of_text ? '0 : pos_n;
		end
	end

endmodule

// ===== src/kmpsm_back.sv =====
// Matcher: walks the skip chain for each queued byte and produces its result item.
module kmpsm_back #(
	parameter int POSITION_BITS = kmpsm_pkg::POSITION_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      restart,
	input  kmpsm_pkg::tbl_t                           tbl,
	input  logic [kmpsm_pkg::CFG_W-1:0]               pattern_low,
	input  logic [kmpsm_pkg::CFG_W-1:0]               pattern_high,
	input  logic                                      in_empty,
	input  logic [POSITION_BITS+kmpsm_pkg::BYTE_W:0]  in_data,
	output logic                                      in_pop,
	output logic [kmpsm_pkg::LEN_W-1:0]               skip_addr,
	input  logic [kmpsm_pkg::LEN_W-1:0]               skip_data,
	input  logic                                      out_full,
	output logic                                      out_push,
	output kmpsm_pkg::out_item_t                      result
);
	import kmpsm_pkg::*;

	typedef enum logic {ST_IDLE, ST_WALK} state_t;

	state_t                   state_q;
	logic [LEN_W-1:0]         y_q;
	logic [BYTE_W-1:0]        c_q;
	logic                     last_q;
	logic [POSITION_BITS-1:0] pos_q;

	logic                     hit, chain_end, done, found;
	logic [LEN_W-1:0]         y_next;
	logic [START_W-1:0]       pos32, start;

	assign skip_addr = y_q;
	assign hit       = (c_q == pat_byte(pattern_low, pattern_high, y_q[3:0]));
	assign chain_end = (skip_data == SKIP_NONE) || (skip_data >= tbl.len);
	assign done      = hit || chain_end;
	assign y_next    = hit ? y_q + LEN_W'(1) : '0;
	assign found     = (y_next >= tbl.len);
	assign pos32     = START_W'(pos_q);
	assign start     = pos32 - START_W'(tbl.len) + START_W'(1);

	assign in_pop   = (state_q == ST_IDLE) && !in_empty && tbl.ready;
	assign out_push = (state_q == ST_WALK) && done && !out_full;

	assign result.match_found = found;
	assign result.match_start = found ? start : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			y_q     <= '0;
		end else if (restart) begin
			state_q <= ST_IDLE;
			y_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_pop) begin
						state_q <= ST_WALK;
						if (y_q >= tbl.len) begin
							y_q <= '0;
						end
					end
				end
				ST_WALK: begin
					if (!done) begin
						y_q <= skip_data;
					end else if (!out_full) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							y_q <= '0;
						end else if (found) begin
							y_q <= tbl.border_full;
						end else begin
							y_q <= y_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			pos_q  <= in_data[POSITION_BITS+BYTE_W:BYTE_W+1];
			c_q    <= in_data[BYTE_W:1];
			last_q <= in_data[0];
		end
	end

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tbl.ready |-> (y_q < tbl.len))
		else $error("matched length reached the pattern length outside a match");

endmodule

// ===== src/kmp_stream_matcher_unit.sv =====
// Top level of the streaming Knuth-Morris-Pratt matcher.
//
// This block searches a byte stream for a pattern of up to MAX_PATTERN bytes held in three
// configuration registers (pattern_low, pattern_high, pattern_length). Each text byte pushed
// in gives exactly one result item: match_found is set when a full occurrence of the pattern
// ends on that byte, and match_start then holds the 1-based position of its first byte
// (otherwise 0). Overlapping occurrences are reported. A byte with end_of_text set closes the
// text: its result is given normally and the next byte starts a new text at position 1. The
// position counter is POSITION_BITS wide and saturates. After reset and after each register
// write the block derives its border and skip tables, and full stays high meanwhile: an
// init step, then the border table, falling back along border links where a byte fails,
// then the skip table, one entry per pattern byte. Write registers only while the block is
// idle. In steady state the matcher takes a byte off the input queue and then compares it
// along the skip chain, following one link per comparison, until the byte extends the
// current match or the chain ends; it takes no new byte until the result of the last one
// has gone into the result queue, which can stall it. Since the matched length rises by at
// most one per byte, the links followed average under one per byte. Two-entry queues on
// both sides let input and result traffic stall independently of the matcher.
module kmp_stream_matcher_unit #(
	parameter int MAX_PATTERN   = kmpsm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = kmpsm_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  kmpsm_pkg::in_item_t              item,
	output logic                             empty,
	input  logic                             pop,
	output kmpsm_pkg::out_item_t             result,
	input  logic                             cfg_we,
	input  logic [kmpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kmpsm_pkg::CFG_W-1:0]      cfg_data
);
	import kmpsm_pkg::*;

	localparam int EW = POSITION_BITS + BYTE_W + 1;
	localparam int RW = $bits(out_item_t);

	// Table unit status, shared by both halves, and the pattern for the matcher.
	tbl_t             tbl;
	logic             restart;
	logic [CFG_W-1:0] pattern_low;
	logic [CFG_W-1:0] pattern_high;
	logic [LEN_W-1:0] skip_addr;
	logic [LEN_W-1:0] skip_data;

	// Queue between the front and the matcher.
	logic             inq_push, inq_pop, inq_full, inq_empty;
	logic [EW-1:0]    inq_wdata, inq_rdata;

	// Result queue.
	logic             outq_push, outq_full;
	out_item_t        back_result;
	logic [RW-1:0]    outq_rdata;

	kmpsm_tables #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_tables (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.skip_addr   (skip_addr),
		.skip_data   (skip_data),
		.pattern_low (pattern_low),
		.pattern_high(pattern_high),
		.restart     (restart),
		.tbl         (tbl)
	);

	// The front numbers each byte so the matcher needs no position counter of its own.
	kmpsm_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.tbl_ready(tbl.ready),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (inq_full),
		.q_push   (inq_push),
		.q_data   (inq_wdata)
	);

	kmpsm_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_in_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (inq_push),
		.wdata (inq_wdata),
		.pop   (inq_pop),
		.rdata (inq_rdata),
		.full  (inq_full),
		.empty (inq_empty)
	);

	kmpsm_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.tbl         (tbl),
		.pattern_low (pattern_low),
		.pattern_high(pattern_high),
		.in_empty    (inq_empty),
		.in_data     (inq_rdata),
		.in_pop      (inq_pop),
		.skip_addr   (skip_addr),
		.skip_data   (skip_data),
		.out_full    (outq_full),
		.out_push    (outq_push),
		.result      (back_result)
	);

	// Results wait here until the consumer pops them.
	kmpsm_fifo #(
		.WIDTH(RW),
		.DEPTH(QUEUE_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (outq_push),
		.wdata (back_result),
		.pop   (pop && !empty),
		.rdata (outq_rdata),
		.full  (outq_full),
		.empty (empty)
	);

	assign result = out_item_t'(outq_rdata);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the streaming KMP matcher, with its own match predictor.
module testbench;
	import kmpsm_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 4;
	// Longest stretch without any item moving on either side. Random stalls and the table
	// derivation after a register write stay far below this.
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 32;
	localparam int REPORT_LIMIT  = 10;
	localparam int PATTERN_SLOTS = 16;
	localparam int PHASE_ITEMS   = 300;
	localparam int PATTERNS_PER_PHASE = 4;

	// Index 3 of the register port holds nothing; a write there must leave the block alone.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	in_item_t             item      = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	out_item_t            result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	kmp_stream_matcher_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Predictor state: a private copy of the registers, the derived tables and the search state.
	logic [CFG_W-1:0]   model_pat_low;
	logic [CFG_W-1:0]   model_pat_high;
	logic [LEN_W-1:0]   model_pat_len;
	logic [LEN_W-1:0]   model_border [0:PATTERN_SLOTS];
	logic [LEN_W-1:0]   model_skip   [0:PATTERN_SLOTS-1];
	logic [LEN_W-1:0]   model_matched;
	logic [START_W-1:0] model_position;

	// Results owed by the block, oldest first.
	out_item_t pending_matches [$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int mismatch_count     = 0;
	int quiet_cycles       = 0;

	// A length of zero behaves as one byte, anything past the slot count as all slots.
	function automatic int effective_length(input logic [LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > PATTERN_SLOTS)
			return PATTERN_SLOTS;
		return int'(len);
	endfunction

	function automatic logic [7:0] pattern_byte_at(input int idx);
		logic [CFG_W-1:0] word;
		word = (idx >= 8) ? model_pat_high : model_pat_low;
		return word[(idx % 8) * 8 +: 8];
	endfunction

	// Derives the border and skip tables from the register copy, and restarts the search,
	// just as any register write does in the block.
	function automatic void rebuild_tables();
		int m;
		int i;
		int k;
		int b;
		m = effective_length(model_pat_len);
		for (i = 0; i <= PATTERN_SLOTS; i++)
			model_border[i] = '0;
		for (i = 0; i < PATTERN_SLOTS; i++)
			model_skip[i] = '0;
		k = 0;
		for (i = 1; i < m; i++) begin
			while (k > 0 && pattern_byte_at(i) != pattern_byte_at(k))
				k = model_border[k];
			if (pattern_byte_at(i) == pattern_byte_at(k))
				k++;
			model_border[i + 1] = k[LEN_W-1:0];
		end
		// The skip chain jumps over borders whose next byte equals the one that just failed.
		model_skip[0] = SKIP_NONE;
		for (i = 1; i < m; i++) begin
			b = model_border[i];
			if (pattern_byte_at(i) == pattern_byte_at(b))
				model_skip[i] = model_skip[b];
			else
				model_skip[i] = b[LEN_W-1:0];
		end
		model_matched  = '0;
		model_position = '0;
	endfunction

	// Advances the search by one text byte and returns the result the block owes for it.
	function automatic out_item_t predict_match(input in_item_t it);
		out_item_t r;
		int        m;
		int        y;
		int        step;
		r = '0;
		m = effective_length(model_pat_len);
		y = model_matched;
		if (y >= m)
			y = 0;
		if (model_position != '1)
			model_position++;
		for (step = 0; step <= PATTERN_SLOTS; step++) begin
			if (it.text_byte == pattern_byte_at(y)) begin
				y++;
				break;
			end
			y = model_skip[y % PATTERN_SLOTS];
			if (y == SKIP_NONE || y >= m) begin
				y = 0;
				break;
			end
		end
		// On a full match the search carries on from the border of the whole pattern, so
		// overlapping occurrences are seen.
		if (y >= m) begin
			r.match_found = 1'b1;
			r.match_start = model_position - m[START_W-1:0] + 32'd1;
			y = model_border[m];
		end
		model_matched = y[LEN_W-1:0];
		if (it.end_of_text) begin
			model_matched  = '0;
			model_position = '0;
		end
		return r;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
	endfunction

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_matches.size() == 0) begin
			note_mismatch($sformatf("unexpected result: match_found %0d, match_start %0d",
				got.match_found, got.match_start));
			return;
		end
		want = pending_matches.pop_front();
		if (got.match_found !== want.match_found)
			note_mismatch($sformatf("match_found: expected %0d, actual %0b",
				want.match_found, got.match_found));
		if (got.match_start !== want.match_start)
			note_mismatch($sformatf("match_start: expected %0d, actual %0d",
				want.match_start, got.match_start));
	endtask

	// Result side: every item popped is checked, and pop is redrawn each cycle so that the
	// stall pattern of the current phase applies.
	always @(posedge clk) begin
		if (pop && !empty)
			check_result(result);
		pop <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Watchdog: any item moving on either side restarts the count.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("kmp_stream_matcher_unit regression: fail");
			$finish;
		end
	end

	// Offers one text byte and waits until the block takes it. Push is left high on return,
	// so back-to-back items go in without a gap; whoever stops sending lowers it.
	task automatic send_text_byte(input logic [7:0] value, input logic last);
		in_item_t it;
		it.text_byte   = value;
		it.end_of_text = last;
		while ($urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_matches.push_back(predict_match(it));
	endtask

	// Stops sending and waits until every result owed has been popped, so that the block is
	// idle and its registers may be written.
	task automatic settle_block();
		push <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Length register data with random upper bits; only the low bits count.
	function automatic logic [CFG_W-1:0] length_word(input int len);
		logic [CFG_W-1:0] w;
		w = {$urandom, $urandom};
		w[LEN_W-1:0] = len[LEN_W-1:0];
		return w;
	endfunction

	// Writes all three pattern registers in consecutive cycles, and optionally the unused index
	// afterwards. Each pattern register write restarts the search, so the predictor follows it edge by edge.
	task automatic write_pattern(input logic [CFG_W-1:0] low_word, input logic [CFG_W-1:0] high_word,
			input logic [CFG_W-1:0] len_word, input bit poke_unused);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PATTERN_LOW;
		cfg_data  <= low_word;
		@(posedge clk);
		model_pat_low = low_word;
		rebuild_tables();
		cfg_index <= REG_PATTERN_HIGH;
		cfg_data  <= high_word;
		@(posedge clk);
		model_pat_high = high_word;
		rebuild_tables();
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data  <= len_word;
		@(posedge clk);
		model_pat_len = len_word[LEN_W-1:0];
		rebuild_tables();
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= {$urandom, $urandom};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// After reset the pattern is a single zero byte: every zero in the text is a match.
	task automatic test_reset_defaults();
		send_text_byte(8'h00, 1'b0);
		send_text_byte(8'hFF, 1'b0);
		send_text_byte(8'h00, 1'b1);
	endtask

	// A length of zero must act as one byte, and a length past the slot count as all slots.
	task automatic test_length_clamping();
		logic [CFG_W-1:0] low_word;
		int               i;
		settle_block();
		low_word = {$urandom, $urandom};
		low_word[7:0] = 8'h61;
		write_pattern(low_word, {$urandom, $urandom}, length_word(0), 1'b0);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h61, 1'b1);
		// Seventeen 0xFF bytes at length 31: one match at the sixteenth byte, and an overlapping
		// one at the seventeenth.
		settle_block();
		write_pattern('1, '1, length_word(31), 1'b0);
		for (i = 0; i <= PATTERN_SLOTS; i++)
			send_text_byte(8'hFF, i == PATTERN_SLOTS);
	endtask

	// Pattern "aba": a write in the middle of a text restarts the position count, and the
	// overlapping occurrences in "ababa" are both found.
	task automatic test_overlap_and_restart();
		logic [CFG_W-1:0] low_word;
		settle_block();
		low_word = {$urandom, $urandom};
		low_word[23:0] = 24'h616261;
		write_pattern(low_word, {$urandom, $urandom}, length_word(3), 1'b0);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h62, 1'b0);
		settle_block();
		write_pattern(low_word, {$urandom, $urandom}, length_word(3), 1'b1);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h62, 1'b0);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h62, 1'b0);
		send_text_byte(8'h61, 1'b1);
	endtask

	// Random search under one idling mix. Patterns are drawn from a small alphabet so that
	// they carry nontrivial borders, and the text mostly replays the pattern with some errors,
	// so that the matcher walks deep into its skip chains. A few bytes are fully random.
	task automatic test_random_search(input int sender_pct, input int receiver_pct,
			input int item_count);
		logic [7:0]       sym [0:2];
		logic [7:0]       pat [0:PATTERN_SLOTS-1];
		logic [CFG_W-1:0] low_word;
		logic [CFG_W-1:0] high_word;
		logic [7:0]       value;
		int               len_code;
		int               used;
		int               alpha;
		int               copy_pos;
		int               copy_left;
		int               roll;
		int               i;
		int               n;
		int               cfg;
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
		for (cfg = 0; cfg < PATTERNS_PER_PHASE; cfg++) begin
			settle_block();
			alpha = $urandom_range(3, 1);
			for (i = 0; i < 3; i++)
				sym[i] = 8'($urandom);
			case ($urandom_range(9))
				0: len_code = 1;
				1: len_code = PATTERN_SLOTS;
				2: len_code = 0;
				3: len_code = $urandom_range(31, PATTERN_SLOTS + 1);
				default: len_code = $urandom_range(PATTERN_SLOTS - 1, 2);
			endcase
			used = effective_length(len_code[LEN_W-1:0]);
			// Bytes past the used length are noise that the block must ignore.
			for (i = 0; i < PATTERN_SLOTS; i++)
				pat[i] = (i < used) ? sym[$urandom_range(alpha - 1)] : 8'($urandom);
			for (i = 0; i < 8; i++) begin
				low_word[i * 8 +: 8]  = pat[i];
				high_word[i * 8 +: 8] = pat[i + 8];
			end
			write_pattern(low_word, high_word, length_word(len_code), $urandom_range(3) == 0);
			copy_left = 0;
			copy_pos  = 0;
			for (n = 0; n < item_count / PATTERNS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (copy_left == 0 && roll < 30) begin
					copy_left = used;
					copy_pos  = 0;
				end
				if (copy_left > 0) begin
					value = ($urandom_range(19) == 0) ? sym[$urandom_range(alpha - 1)]
						: pat[copy_pos];
					copy_pos++;
					copy_left--;
				end else if (roll < 88) begin
					value = sym[$urandom_range(alpha - 1)];
				end else begin
					value = 8'($urandom);
				end
				send_text_byte(value, $urandom_range(49) == 0);
			end
		end
	endtask

	initial begin
		model_pat_low  = '0;
		model_pat_high = '0;
		model_pat_len  = 5'd1;
		rebuild_tables();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_length_clamping();
		test_overlap_and_restart();
		test_random_search(0, 0, PHASE_ITEMS);
		test_random_search(85, 0, PHASE_ITEMS);
		test_random_search(0, 85, PHASE_ITEMS);
		test_random_search(21, 21, PHASE_ITEMS);

		// Everything owed has arrived once settle_block returns; a quiet tail then catches
		// any stray result.
		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("kmp_stream_matcher_unit regression: pass");
		else
			$display("kmp_stream_matcher_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
src/kmpsm_pkg.sv
src/kmpsm_fifo.sv
src/kmpsm_tables.sv
src/kmpsm_front.sv
src/kmpsm_back.sv
src/kmp_stream_matcher_unit.sv
tb/sv/testbench.sv
